// ----- src/bis_pkg.sv -----
`timescale 1ns / 1ps
// shared types and codes for the block index search
package bis_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE_ENTRY = 2'd0,
    CMD_WRITE_MAX   = 2'd1,
    CMD_SEARCH      = 2'd2,
    CMD_UNUSED      = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_BLOCK_LENGTH = 1'b0,
    REG_BLOCK_COUNT  = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INDEX,
    S_BASE,
    S_LIMIT,
    S_TABLE,
    S_DONE
  } state_t;

  localparam int unsigned KEY_W    = 31;
  localparam int unsigned LENGTH_W = 11;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned SLOT_W   = 10;
  localparam int unsigned POS_W    = 11;
  localparam int unsigned PROBE_W  = 11;

endpackage

// ----- src/bis_ram.sv -----
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
module bis_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/block_index_search.sv -----
`timescale 1ns / 1ps
// block index search: index scan over block maxima, then sequential scan of one block
//
//   port group   handshake                 payload
//   item         item_valid / item_stall   cmd, slot, value
//   result       result_valid/result_stall found, position, probes
//   config       cfg_write                 cfg_index, cfg_data
//
// a table or index write is taken in the idle state; a search reads index entries
// (up to block_count) and then block entries (up to block_length), one read per
// cycle from the index ram and then the table ram
// rst is synchronous; both rams hold garbage until written
// a result waiting on result_stall holds the next search in its final state
module block_index_search
  import bis_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned MAX_BLOCKS  = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic [1:0]          cmd,
  input  logic [SLOT_W-1:0]   slot,
  input  logic [KEY_W-1:0]    value,
  output logic                result_valid,
  input  logic                result_stall,
  output logic                found,
  output logic [POS_W-1:0]    position,
  output logic [PROBE_W-1:0]  probes,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [LENGTH_W-1:0] cfg_data
);

  localparam int unsigned AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned BW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned BCW  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned CMPW = (BCW > COUNT_W) ? BCW : COUNT_W;
  localparam int unsigned MW   = ((BW + 12) > (AW + 2)) ? (BW + 12) : (AW + 2);

  // configuration
  logic [LENGTH_W-1:0] block_length;
  logic [COUNT_W-1:0]  block_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_length <= LENGTH_W'(1);
      block_count  <= COUNT_W'(1);
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_BLOCK_LENGTH: block_length <= cfg_data;
        REG_BLOCK_COUNT:  block_count  <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [BCW-1:0] nblk;
  assign nblk = (CMPW'(block_count) > CMPW'(MAX_BLOCKS)) ? BCW'(MAX_BLOCKS)
                                                          : BCW'(block_count);

  // state and registers
  state_t state, state_next;

  logic [KEY_W-1:0]   key, key_next;
  logic [BCW-1:0]     iss, iss_next;
  logic               ipend, ipend_next;
  logic [BW-1:0]      ipend_blk, ipend_blk_next;
  logic [BW-1:0]      blk, blk_next;
  logic [MW-1:0]      base, base_next;
  logic [MW-1:0]      tlim, tlim_next;
  logic [MW-1:0]      tiss, tiss_next;
  logic               tpend, tpend_next;
  logic [MW-1:0]      tpaddr, tpaddr_next;
  logic [PROBE_W-1:0] tprobe, tprobe_next;
  logic [PROBE_W-1:0] tpprobe, tpprobe_next;
  logic               res_found, res_found_next;
  logic [POS_W-1:0]   res_pos, res_pos_next;
  logic [PROBE_W-1:0] res_probes, res_probes_next;

  // memories
  logic             main_we, max_we;
  logic [AW-1:0]    main_waddr, main_raddr;
  logic [BW-1:0]    max_waddr, max_raddr;
  logic [KEY_W-1:0] main_rd, max_rd;

  bis_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_main_ram (
    .clk   (clk),
    .we    (main_we),
    .waddr (main_waddr),
    .wdata (value),
    .raddr (main_raddr),
    .rdata (main_rd)
  );

  bis_ram #(.WIDTH(KEY_W), .DEPTH(MAX_BLOCKS)) u_max_ram (
    .clk   (clk),
    .we    (max_we),
    .waddr (max_waddr),
    .wdata (value),
    .raddr (max_raddr),
    .rdata (max_rd)
  );

  // scan conditions
  logic item_take;
  logic idx_hit, idx_issue, idx_fail;
  logic tab_hit, tab_issue, tab_fail;
  logic [MW-1:0] block_end, block_stop;
  logic limit_fail;
  logic out_free;

  assign item_take  = item_valid && !item_stall;
  assign idx_hit    = ipend && (max_rd >= key);
  assign idx_issue  = iss < nblk;
  assign idx_fail   = !ipend && !idx_issue;
  assign tab_hit    = tpend && (main_rd == key);
  assign tab_issue  = tiss < tlim;
  assign tab_fail   = !tpend && !tab_issue;
  assign block_end  = base + MW'(block_length);
  assign block_stop = (block_end > MW'(TABLE_DEPTH)) ? MW'(TABLE_DEPTH) : block_end;
  assign limit_fail = (block_length == '0) || (base >= MW'(TABLE_DEPTH));
  assign out_free   = !result_valid || !result_stall;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_take && cmd_t'(cmd) == CMD_SEARCH) state_next = S_INDEX;
      end
      S_INDEX: begin
        if (idx_hit) state_next = S_BASE;
        else if (idx_fail) state_next = S_DONE;
      end
      S_BASE:  state_next = S_LIMIT;
      S_LIMIT: state_next = limit_fail ? S_DONE : S_TABLE;
      S_TABLE: begin
        if (tab_hit || tab_fail) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    item_stall = 1'b1;
    main_we    = 1'b0;
    max_we     = 1'b0;
    unique case (state)
      S_IDLE: begin
        item_stall = 1'b0;
        main_we = item_valid && cmd_t'(cmd) == CMD_WRITE_ENTRY &&
                  (32'(slot) < 32'(TABLE_DEPTH));
        max_we  = item_valid && cmd_t'(cmd) == CMD_WRITE_MAX &&
                  (32'(slot) < 32'(MAX_BLOCKS));
      end
      S_INDEX, S_BASE, S_LIMIT, S_TABLE, S_DONE: item_stall = 1'b1;
      default: item_stall = 1'b1;
    endcase
  end

  assign main_waddr = AW'(slot);
  assign max_waddr  = BW'(slot);
  assign max_raddr  = iss[BW-1:0];
  assign main_raddr = tiss[AW-1:0];

  // datapath
  always_comb begin
    key_next        = key;
    iss_next        = iss;
    ipend_next      = ipend;
    ipend_blk_next  = ipend_blk;
    blk_next        = blk;
    base_next       = base;
    tlim_next       = tlim;
    tiss_next       = tiss;
    tpend_next      = tpend;
    tpaddr_next     = tpaddr;
    tprobe_next     = tprobe;
    tpprobe_next    = tpprobe;
    res_found_next  = res_found;
    res_pos_next    = res_pos;
    res_probes_next = res_probes;
    case (state)
      S_IDLE: begin
        key_next   = value;
        iss_next   = '0;
        ipend_next = 1'b0;
      end
      S_INDEX: begin
        // one index read in flight, compare it while issuing the next
        blk_next       = ipend_blk;
        ipend_next     = idx_issue;
        ipend_blk_next = iss[BW-1:0];
        if (idx_issue) iss_next = iss + BCW'(1);
        res_found_next  = 1'b0;
        res_pos_next    = '0;
        res_probes_next = '0;
      end
      S_BASE: begin
        base_next = MW'(blk) * MW'(block_length);
      end
      S_LIMIT: begin
        tlim_next   = block_stop;
        tiss_next   = base;
        tpend_next  = 1'b0;
        tprobe_next = PROBE_W'(blk) + PROBE_W'(2);
      end
      S_TABLE: begin
        tpend_next   = tab_issue;
        tpaddr_next  = tiss;
        tpprobe_next = tprobe;
        if (tab_issue) begin
          tiss_next   = tiss + MW'(1);
          tprobe_next = tprobe + PROBE_W'(1);
        end
        if (tab_hit) begin
          res_found_next  = 1'b1;
          res_pos_next    = tpaddr[POS_W-1:0] + POS_W'(1);
          res_probes_next = tpprobe;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ipend <= 1'b0;
      tpend <= 1'b0;
    end else begin
      state <= state_next;
      ipend <= ipend_next;
      tpend <= tpend_next;
    end
    key        <= key_next;
    iss        <= iss_next;
    ipend_blk  <= ipend_blk_next;
    blk        <= blk_next;
    base       <= base_next;
    tlim       <= tlim_next;
    tiss       <= tiss_next;
    tpaddr     <= tpaddr_next;
    tprobe     <= tprobe_next;
    tpprobe    <= tpprobe_next;
    res_found  <= res_found_next;
    res_pos    <= res_pos_next;
    res_probes <= res_probes_next;
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      found    <= res_found;
      position <= res_pos;
      probes   <= res_probes;
    end
  end

  // checks
  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> item_stall)
    else $error("item taken while a search is running");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !found |-> position == '0 && probes == '0)
    else $error("failed search carries nonzero position or probes");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    state == S_INDEX && ipend |-> BCW'(ipend_blk) < nblk)
    else $error("index read beyond the blocks in use");

  a_table_range: assert property (@(posedge clk) disable iff (rst)
    state == S_TABLE && tpend |-> tpaddr < MW'(TABLE_DEPTH))
    else $error("table read beyond the table end");

endmodule

// ----- tb/block_index_search_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the block index search
module block_index_search_tb;
  import bis_pkg::*;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned MAX_BLOCKS  = 64;
  localparam int unsigned SETTLE      = 16;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned ITEM_GOAL   = 550;
  localparam int unsigned BUILD_CAP   = 96;

  typedef struct packed {
    logic               found;
    logic [POS_W-1:0]   position;
    logic [PROBE_W-1:0] probes;
  } search_result_t;

  typedef struct {
    bit                  is_cfg;
    reg_index_t          reg_sel;
    cmd_t                op;
    logic [SLOT_W-1:0]   slot;
    logic [KEY_W-1:0]    value;
    bit                  typed;
    search_result_t      want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_stall;
  logic [1:0]          cmd = CMD_WRITE_ENTRY;
  logic [SLOT_W-1:0]   slot = '0;
  logic [KEY_W-1:0]    value = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  logic                found;
  logic [POS_W-1:0]    position;
  logic [PROBE_W-1:0]  probes;
  logic                cfg_write = 1'b0;
  logic                cfg_index = REG_BLOCK_LENGTH;
  logic [LENGTH_W-1:0] cfg_data = '0;

  // own copy of the tables, with written flags so no unwritten entry gets probed
  bit [KEY_W-1:0]    tab_mem [TABLE_DEPTH];
  bit                tab_set [TABLE_DEPTH];
  bit [KEY_W-1:0]    max_mem [MAX_BLOCKS];
  bit                max_set [MAX_BLOCKS];
  bit [LENGTH_W-1:0] blk_len = 1;
  bit [COUNT_W-1:0]  blk_cnt = 1;

  search_result_t pending_results[$];
  dir_row_t       dir_rows[$];
  int             errors = 0;
  int             scored = 0;
  int             burst_left = 0;
  bit             hold_request = 0;

  block_index_search #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .cmd         (cmd),
    .slot        (slot),
    .value       (value),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .found       (found),
    .position    (position),
    .probes      (probes),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int eff_blocks();
    return (blk_cnt > MAX_BLOCKS) ? MAX_BLOCKS : blk_cnt;
  endfunction

  // index scan then in-block scan; reports the first unwritten entry it would read
  function automatic void find_key(input bit [KEY_W-1:0] key, output search_result_t res,
                                   output int miss_idx, output int miss_tab);
    int b;
    int p;
    int start;
    int stop;
    res = '0;
    miss_idx = -1;
    miss_tab = -1;
    for (b = 0; b < eff_blocks(); b++) begin
      if (!max_set[b]) begin
        miss_idx = b;
        return;
      end
      if (max_mem[b] >= key) begin
        start = 1 + b * blk_len;
        stop  = start + blk_len;
        for (p = start; p < stop && p <= TABLE_DEPTH; p++) begin
          if (!tab_set[p-1]) begin
            miss_tab = p - 1;
            return;
          end
          if (tab_mem[p-1] == key) begin
            res.found    = 1'b1;
            res.position = POS_W'(p);
            res.probes   = PROBE_W'((p - start + 1) + (b + 1));
            return;
          end
        end
        return;
      end
    end
  endfunction

  function automatic dir_row_t item_row(cmd_t op, logic [SLOT_W-1:0] s, logic [KEY_W-1:0] v,
                                        bit typed = 0, logic f = 0,
                                        logic [POS_W-1:0] pos = 0, logic [PROBE_W-1:0] n = 0);
    dir_row_t r;
    r.is_cfg  = 0;
    r.reg_sel = REG_BLOCK_LENGTH;
    r.op      = op;
    r.slot    = s;
    r.value   = v;
    r.typed   = typed;
    r.want    = '{found: f, position: pos, probes: n};
    return r;
  endfunction

  function automatic dir_row_t cfg_row(reg_index_t sel, logic [LENGTH_W-1:0] d);
    dir_row_t r;
    r = item_row(CMD_UNUSED, '0, KEY_W'(d));
    r.is_cfg  = 1;
    r.reg_sel = sel;
    return r;
  endfunction

  // offer one word in bursts; returns at the edge where it is taken (valid still high)
  task automatic drive_item(cmd_t op, logic [SLOT_W-1:0] s, logic [KEY_W-1:0] v,
                            bit typed = 0, search_result_t want = '0);
    int gap;
    search_result_t res;
    int mi;
    int mt;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    if (gap > 0) begin
      @(negedge clk);
      item_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    item_valid <= 1'b1;
    cmd        <= op;
    slot       <= s;
    value      <= v;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    case (op)
      CMD_WRITE_ENTRY: begin
        tab_mem[s] = v;
        tab_set[s] = 1;
        scored++;
      end
      CMD_WRITE_MAX: begin
        if (s < MAX_BLOCKS) begin
          max_mem[s] = v;
          max_set[s] = 1;
          scored++;
        end
      end
      CMD_SEARCH: begin
        find_key(v, res, mi, mt);
        pending_results.push_back(typed ? want : res);
        scored++;
      end
      default: ;
    endcase
  endtask

  task automatic drain_results();
    @(negedge clk);
    item_valid <= 1'b0;
    wait (pending_results.size() == 0);
  endtask

  // loads leave no result behind, so give the last one time to land
  task automatic settle_block();
    drain_results();
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t sel, logic [LENGTH_W-1:0] d);
    @(negedge clk);
    item_valid <= 1'b0;
    cfg_write  <= 1'b1;
    cfg_index  <= sel;
    cfg_data   <= d;
    if (sel == REG_BLOCK_LENGTH) blk_len = d;
    else blk_cnt = d[COUNT_W-1:0];
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // fill whatever the scan would read unwritten, then search
  task automatic search_key(bit [KEY_W-1:0] key);
    search_result_t res;
    int mi;
    int mt;
    forever begin
      find_key(key, res, mi, mt);
      if (mi >= 0) drive_item(CMD_WRITE_MAX, SLOT_W'(mi), KEY_W'($urandom));
      else if (mt >= 0) drive_item(CMD_WRITE_ENTRY, SLOT_W'(mt), KEY_W'($urandom));
      else break;
    end
    drive_item(CMD_SEARCH, '0, key);
  endtask

  // ascending keys per block, block max in the index, or the top key for the last block
  task automatic build_blocks();
    int nb;
    int b;
    int i;
    int unsigned step;
    bit [KEY_W-1:0] v;
    if (blk_len == 0) return;
    nb = BUILD_CAP / blk_len;
    if (nb > eff_blocks()) nb = eff_blocks();
    if (nb == 0) return;
    step = 32'h7FFF_FFFF / (nb * blk_len + 1);
    v = KEY_W'($urandom_range(0, step));
    for (b = 0; b < nb; b++) begin
      for (i = 0; i < blk_len; i++) begin
        drive_item(CMD_WRITE_ENTRY, SLOT_W'(b * blk_len + i), v);
        v = v + KEY_W'($urandom_range(1, step));
      end
      drive_item(CMD_WRITE_MAX, SLOT_W'(b),
                 (b == nb - 1 && $urandom_range(0, 1)) ? KEY_W'(32'h7FFF_FFFF)
                                                       : tab_mem[b * blk_len + blk_len - 1]);
    end
  endtask

  // receiver: own stall pattern, plus a long hold-off on request
  initial begin
    int mode_left;
    int stall_mode;
    int hold_left;
    int tick;
    mode_left = 0;
    stall_mode = 0;
    hold_left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_left == 0 && hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 0;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 160);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: result_stall <= 1'b0;
          1: result_stall <= $urandom_range(0, 1);
          2: result_stall <= ($urandom_range(0, 9) < 8);
          default: result_stall <= ((tick % 5) < 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    search_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: found %0d position %0d probes %0d",
               found, position, probes);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found);
          errors++;
        end
        if (position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, position);
          errors++;
        end
        if (probes !== want.probes) begin
          $error("probes: expected %0d, got %0d", want.probes, probes);
          errors++;
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int ph_num;
    int n_ops;
    int k;
    int r;
    int s;
    int span;
    int len;
    int cnt;
    bit [KEY_W-1:0] key;
    bit [3:0] upper;

    // directed part; rams hold garbage until written, so every word compared is loaded
    dir_rows.push_back(item_row(CMD_WRITE_MAX,   0, 31'h7FFF_FFFF));
    dir_rows.push_back(item_row(CMD_WRITE_ENTRY, 0, 31'd0));
    dir_rows.push_back(item_row(CMD_SEARCH,      0, 31'd0, 1, 1, 1, 2));
    dir_rows.push_back(item_row(CMD_SEARCH,      0, 31'h7FFF_FFFF, 1));
    dir_rows.push_back(item_row(CMD_WRITE_ENTRY, 1023, 31'h7FFF_FFFF));
    dir_rows.push_back(item_row(CMD_WRITE_MAX,   1023, 31'd0));
    dir_rows.push_back(item_row(CMD_UNUSED,      0, 31'd55));
    dir_rows.push_back(item_row(CMD_SEARCH,      0, 31'd55, 1));
    dir_rows.push_back(item_row(CMD_WRITE_MAX,   0, 31'd100));
    // key above every block max
    dir_rows.push_back(item_row(CMD_SEARCH,      0, 31'd101, 1));
    dir_rows.push_back(item_row(CMD_WRITE_ENTRY, 1, 31'd100));
    dir_rows.push_back(item_row(CMD_WRITE_MAX,   1, 31'h7FFF_FFFF));
    dir_rows.push_back(item_row(CMD_WRITE_ENTRY, 2, 31'd200));
    dir_rows.push_back(item_row(CMD_WRITE_ENTRY, 3, 31'h7FFF_FFFF));
    dir_rows.push_back(cfg_row(REG_BLOCK_LENGTH, 2));
    dir_rows.push_back(cfg_row(REG_BLOCK_COUNT, 2));
    dir_rows.push_back(item_row(CMD_SEARCH,      0, 31'd100));
    dir_rows.push_back(item_row(CMD_SEARCH,      0, 31'h7FFF_FFFF));
    dir_rows.push_back(item_row(CMD_SEARCH,      0, 31'd150));
    // no blocks in use
    dir_rows.push_back(cfg_row(REG_BLOCK_COUNT, 0));
    dir_rows.push_back(item_row(CMD_SEARCH,      0, 31'd0, 1));
    // empty blocks
    dir_rows.push_back(cfg_row(REG_BLOCK_COUNT, 2));
    dir_rows.push_back(cfg_row(REG_BLOCK_LENGTH, 0));
    dir_rows.push_back(item_row(CMD_SEARCH,      0, 31'd0, 1));
    // second block starts past the table end
    dir_rows.push_back(cfg_row(REG_BLOCK_LENGTH, 1024));
    dir_rows.push_back(item_row(CMD_SEARCH,      0, 31'h7FFF_FFFF, 1));
    dir_rows.push_back(item_row(CMD_SEARCH,      0, 31'd0, 1, 1, 1, 2));
    // widest length, count saturates
    dir_rows.push_back(cfg_row(REG_BLOCK_LENGTH, 11'h7FF));
    dir_rows.push_back(cfg_row(REG_BLOCK_COUNT, 127));
    dir_rows.push_back(item_row(CMD_SEARCH,      0, 31'd0, 1, 1, 1, 2));
    dir_rows.push_back(item_row(CMD_SEARCH,      0, 31'h7FFF_FFFF, 1));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        settle_block();
        write_reg(dir_rows[i].reg_sel, LENGTH_W'(dir_rows[i].value));
      end else begin
        drive_item(dir_rows[i].op, dir_rows[i].slot, dir_rows[i].value,
                   dir_rows[i].typed, dir_rows[i].want);
      end
    end

    scored = 0;
    ph_num = 0;
    while (scored < ITEM_GOAL || ph_num < 6) begin
      case (ph_num)
        1: begin
          len = 0;
          cnt = $urandom_range(1, 8);
        end
        2: begin
          len = $urandom_range(1, 4);
          cnt = 127;
        end
        3: begin
          case ($urandom_range(0, 2))
            0: len = 1024;
            1: len = 2047;
            default: len = $urandom_range(100, 1023);
          endcase
          cnt = $urandom_range(1, 3);
        end
        4: begin
          len = $urandom_range(1, 16);
          cnt = 0;
        end
        5: begin
          len = 16;
          cnt = 64;
        end
        default: begin
          len = $urandom_range(1, 16);
          cnt = $urandom_range(1, 12);
        end
      endcase
      // bits above the count field are don't care
      upper = (ph_num % 3 == 2) ? 4'($urandom) : 4'd0;
      settle_block();
      write_reg(REG_BLOCK_LENGTH, LENGTH_W'(len));
      write_reg(REG_BLOCK_COUNT, {upper, COUNT_W'(cnt)});
      build_blocks();

      span = eff_blocks() * blk_len;
      if (span > TABLE_DEPTH) span = TABLE_DEPTH;
      if (span < 1) span = 1;
      n_ops = (ph_num == 3) ? 12 : $urandom_range(30, 60);
      if (ph_num == 0 || ph_num == 5) hold_request = 1;

      for (k = 0; k < n_ops; k++) begin
        if (k == n_ops / 2 && ph_num % 2 == 1) drain_results();
        r = $urandom_range(0, 99);
        if (r < 55) begin
          s = $urandom_range(0, span - 1);
          key = tab_set[s] ? tab_mem[s] : KEY_W'($urandom);
          search_key(key);
        end else if (r < 68) begin
          case ($urandom_range(0, 3))
            0: key = KEY_W'($urandom);
            1: key = '0;
            2: key = KEY_W'(32'h7FFF_FFFF);
            default: key = max_mem[$urandom_range(0, MAX_BLOCKS - 1)] +
                           KEY_W'($urandom_range(0, 1));
          endcase
          search_key(key);
        end else if (r < 80) begin
          s = $urandom_range(0, 1) ? $urandom_range(0, span - 1)
                                   : $urandom_range(0, TABLE_DEPTH - 1);
          drive_item(CMD_WRITE_ENTRY, SLOT_W'(s), KEY_W'($urandom));
        end else if (r < 88) begin
          drive_item(CMD_WRITE_MAX, SLOT_W'($urandom_range(0, MAX_BLOCKS - 1)),
                     KEY_W'($urandom));
        end else if (r < 94) begin
          drive_item(CMD_WRITE_MAX, SLOT_W'($urandom_range(MAX_BLOCKS, TABLE_DEPTH - 1)),
                     KEY_W'($urandom));
        end else begin
          drive_item(CMD_UNUSED, SLOT_W'($urandom), KEY_W'($urandom));
        end
      end
      ph_num++;
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- block_index_search.f -----
src/bis_pkg.sv
src/bis_ram.sv
src/block_index_search.sv
tb/block_index_search_tb.sv
